// ===== hdl/pal_pkg.sv =====
// Package for the positional array list: field widths, action and status codes,
// controller states and the control bundle broadcast to every storage cell.
// Used by pal_cell and positional_array_list; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_GET    = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_BADPOS   = 3'd2,
        STS_EMPTY    = 3'd3,
        STS_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DELETE = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd          cmd;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
        t_data              value;
        logic               probe_adv;
        logic               probe_clr;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/pal_cell.sv =====
// One storage cell of the list chain: holds one entry and a search probe bit.
// Takes its neighbours' entries on insert and delete; depends on pal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell
    import pal_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic [COUNT_W-1:0] i_index,
    input  wire t_data              i_prev_data,
    input  wire t_data              i_next_data,
    input  wire logic               i_prev_probe,
    output t_data                   o_data,
    output logic                    o_probe,
    output logic                    o_hit
);

    t_data r_data;
    t_data n_data;
    logic  r_probe;
    logic  n_probe;

    always_comb begin
        n_data = r_data;
        case (i_ctl.cmd)
            CMD_APPEND: begin
                if (i_index == i_ctl.count) begin
                    n_data = i_ctl.value;
                end
            end
            CMD_INSERT: begin
                if (i_index == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end else if ((i_index > i_ctl.pos) && (i_index <= i_ctl.count)) begin
                    n_data = i_prev_data;
                end
            end
            CMD_DELETE: begin
                if ((i_index >= i_ctl.pos) &&
                    (({1'b0, i_index} + 9'd1) < {1'b0, i_ctl.count})) begin
                    n_data = i_next_data;
                end
            end
            default: begin
            end
        endcase
    end

    // The probe walks one cell per cycle while a find is under way.
    always_comb begin
        if (i_ctl.probe_clr) begin
            n_probe = 1'b0;
        end else if (i_ctl.probe_adv) begin
            n_probe = i_prev_probe;
        end else begin
            n_probe = r_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_data  = r_data;
    assign o_probe = r_probe;
    assign o_hit   = r_probe && (r_data == i_ctl.value);

endmodule

`default_nettype wire

// ===== hdl/positional_array_list.sv =====
// Top level of the positional array list: request decode, find sequencer,
// result register and the chain of pal_cell storage cells; depends on pal_pkg.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+--------------------------------------------
//  request  | i_in_valid / o_in_stall    | i_action, i_position, i_value
//  result   | o_out_valid / i_out_stall  | o_status, o_found_index, o_read_value,
//           |                            | o_count, o_is_empty
//  config   | i_cfg_we                   | i_cfg_wdata (error fill value)
//
// Append, insert, delete, get and unused actions need no sequencing: the cells shift
// in parallel and the result is registered at the accepting edge. Find walks a
// probe down the cell chain one cell per cycle until it meets a match or the tail
// of the list. Reset clears the count, the probes and the result valid flag, not
// the result payload; entries hold garbage until written. A request is taken only
// in idle while the result register is empty or being emptied.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list
    import pal_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic signed [DATA_W-1:0] i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [POS_W-1:0]         o_found_index,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_is_empty
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(LIST_DEPTH);

    t_state r_state;
    t_state n_state;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_data              r_fill;
    t_data              r_key;
    logic [COUNT_W-1:0] r_idx;
    logic [COUNT_W-1:0] n_idx;

    logic                r_out_valid;
    t_status             r_status;
    logic [POS_W-1:0]    r_found;
    t_data               r_rdval;
    logic [COUNT_W-1:0]  r_out_count;

    t_cell_ctl w_ctl;
    t_data     w_data  [LIST_DEPTH];
    logic      w_probe [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_hit_vec;
    logic      w_hit;
    logic      w_probe_start;
    logic      w_out_free;
    logic      w_in_acc;
    logic      w_load;
    logic      w_scan_end;
    logic      w_scan_miss;
    t_status   w_status;
    logic [POS_W-1:0] w_found;
    t_data     w_rdval;
    t_data     w_get_data;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_hit      = |w_hit_vec;
    assign w_get_data = w_data[i_position[IDX_W-1:0]];

    // A probe past the tail may sit on stale data, so the tail check comes first.
    assign w_scan_miss = (r_idx >= r_count);
    assign w_scan_end  = w_scan_miss || w_hit;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (t_action'(i_action) == ACT_FIND)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end && w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Cell control, count update and result for the current beat.
    always_comb begin
        w_ctl           = '0;
        w_ctl.cmd       = CMD_HOLD;
        w_ctl.pos       = i_position;
        w_ctl.count     = r_count;
        w_ctl.value     = i_value;
        w_probe_start   = 1'b0;
        n_count         = r_count;
        n_idx           = r_idx;
        w_load          = 1'b0;
        w_status        = STS_OK;
        w_found         = '0;
        w_rdval         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_action)
                        ACT_APPEND: begin
                            w_load = 1'b1;
                            if (r_count >= DEPTH_C) begin
                                w_status = STS_FULL;
                            end else begin
                                w_ctl.cmd = CMD_APPEND;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        ACT_INSERT: begin
                            w_load = 1'b1;
                            if (r_count >= DEPTH_C) begin
                                w_status = STS_FULL;
                            end else if (i_position > r_count) begin
                                w_status = STS_BADPOS;
                            end else begin
                                w_ctl.cmd = CMD_INSERT;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        ACT_DELETE: begin
                            w_load = 1'b1;
                            if (r_count == '0) begin
                                w_status = STS_EMPTY;
                            end else if (i_position >= r_count) begin
                                w_status = STS_BADPOS;
                            end else begin
                                w_ctl.cmd = CMD_DELETE;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        ACT_FIND: begin
                            w_ctl.probe_adv = 1'b1;
                            w_probe_start   = 1'b1;
                            n_idx           = '0;
                        end
                        ACT_GET: begin
                            w_load = 1'b1;
                            if (r_count == '0) begin
                                w_status = STS_EMPTY;
                                w_rdval  = r_fill;
                            end else if (i_position >= r_count) begin
                                w_status = STS_BADPOS;
                                w_rdval  = r_fill;
                            end else begin
                                w_rdval = w_get_data;
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_ctl.value = r_key;
                if (w_scan_end) begin
                    if (w_out_free) begin
                        w_load          = 1'b1;
                        w_ctl.probe_clr = 1'b1;
                        if (w_scan_miss) begin
                            w_status = STS_NOTFOUND;
                        end else begin
                            w_found = r_idx;
                        end
                    end
                end else begin
                    w_ctl.probe_adv = 1'b1;
                    n_idx           = r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= (r_out_valid && i_out_stall) || w_load;
            if (i_cfg_we) begin
                r_fill <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key <= i_value;
        end
        if (w_load) begin
            r_status    <= w_status;
            r_found     <= w_found;
            r_rdval     <= w_rdval;
            r_out_count <= n_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            t_data w_prev;
            t_data w_next;
            logic  w_pprobe;

            if (g == 0) begin : g_head
                assign w_prev   = w_ctl.value;
                assign w_pprobe = w_probe_start;
            end else begin : g_body
                assign w_prev   = w_data[g-1];
                assign w_pprobe = w_probe[g-1];
            end

            if (g == LIST_DEPTH - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_data[g+1];
            end

            pal_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_index      (COUNT_W'(g)),
                .i_prev_data  (w_prev),
                .i_next_data  (w_next),
                .i_prev_probe (w_pprobe),
                .o_data       (w_data[g]),
                .o_probe      (w_probe[g]),
                .o_hit        (w_hit_vec[g])
            );
        end
    endgenerate

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_read_value  = r_rdval;
    assign o_count       = r_out_count;
    assign o_is_empty    = (r_out_count == '0);

endmodule

`default_nettype wire

// ===== dv/positional_array_list_test.sv =====
// Self-checking testbench for positional_array_list: a scoreboard class keeps a
// shadow copy of the list and predicts every result beat from the accepted requests.
// Depends on pal_pkg and the positional_array_list RTL only.
`timescale 1ns / 1ps

module positional_array_list_test;
    import pal_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int HOLD_CYCLES = 300;

    // Action codes above ACT_GET are not used by the block and must be ignored.
    localparam int ACT_SPARE_FIRST = 5;
    localparam int ACT_SPARE_LAST  = 7;

    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct {
        t_status            status;
        logic [POS_W-1:0]   found_index;
        t_data              read_value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } t_reply;

    class pal_scoreboard;
        t_data       store [LIST_DEPTH];
        int unsigned used;
        t_data       fill_value = '0;
        t_reply      replies_due [$];
        int unsigned requests;
        int unsigned replies;
        int unsigned errors;
        int unsigned full_hits;
        int unsigned empty_hits;
        int unsigned fill_writes;

        function void set_fill(t_data v);
            fill_value = v;
            fill_writes++;
        endfunction

        // Work out the reply to one accepted request and update the shadow list.
        function void apply_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                    t_data val);
            t_reply r;
            int     i;
            r.status      = STS_OK;
            r.found_index = '0;
            r.read_value  = '0;
            requests++;
            case (act)
                ACT_APPEND: begin
                    if (used >= LIST_DEPTH) begin
                        r.status = STS_FULL;
                    end else begin
                        store[used] = val;
                        used++;
                    end
                end
                ACT_INSERT: begin
                    if (used >= LIST_DEPTH) begin
                        r.status = STS_FULL;
                    end else if (pos > used) begin
                        r.status = STS_BADPOS;
                    end else begin
                        for (i = int'(used); i > int'(pos); i--) begin
                            store[i] = store[i-1];
                        end
                        store[pos] = val;
                        used++;
                    end
                end
                ACT_DELETE: begin
                    if (used == 0) begin
                        r.status = STS_EMPTY;
                    end else if (pos >= used) begin
                        r.status = STS_BADPOS;
                    end else begin
                        for (i = int'(pos); i + 1 < int'(used); i++) begin
                            store[i] = store[i+1];
                        end
                        used--;
                    end
                end
                ACT_FIND: begin
                    r.status = STS_NOTFOUND;
                    for (i = 0; i < int'(used) && r.status == STS_NOTFOUND; i++) begin
                        if (store[i] == val) begin
                            r.status      = STS_OK;
                            r.found_index = POS_W'(i);
                        end
                    end
                end
                ACT_GET: begin
                    if (used == 0) begin
                        r.status     = STS_EMPTY;
                        r.read_value = fill_value;
                    end else if (pos >= used) begin
                        r.status     = STS_BADPOS;
                        r.read_value = fill_value;
                    end else begin
                        r.read_value = store[pos];
                    end
                end
                default: begin
                end
            endcase
            r.count    = COUNT_W'(used);
            r.is_empty = (used == 0);
            if (r.status == STS_FULL) full_hits++;
            if (r.status == STS_EMPTY) empty_hits++;
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic [POS_W-1:0] idx,
                                  t_data rd, logic [COUNT_W-1:0] cnt, logic emp);
            t_reply r;
            replies++;
            if (replies_due.size() == 0) begin
                $error("result beat with no request outstanding: status %0d, count %0d",
                       st, cnt);
                errors++;
            end else begin
                r = replies_due.pop_front();
                if (r.status !== st) begin
                    $error("status: expected %0d, got %0d", r.status, st);
                    errors++;
                end
                if (r.found_index !== idx) begin
                    $error("found_index: expected %0d, got %0d", r.found_index, idx);
                    errors++;
                end
                if (r.read_value !== rd) begin
                    $error("read_value: expected %0d, got %0d", r.read_value, rd);
                    errors++;
                end
                if (r.count !== cnt) begin
                    $error("count: expected %0d, got %0d", r.count, cnt);
                    errors++;
                end
                if (r.is_empty !== emp) begin
                    $error("is_empty: expected %0d, got %0d", r.is_empty, emp);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    t_data                i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [ACTION_W-1:0]  i_action    = '0;
    logic [POS_W-1:0]     i_position  = '0;
    t_data                i_value     = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [POS_W-1:0]     o_found_index;
    t_data                o_read_value;
    logic [COUNT_W-1:0]   o_count;
    logic                 o_is_empty;

    pal_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_asked    = 0;
    int unsigned hold_served   = 0;
    int unsigned target_len    = 0;
    int unsigned seg_left      = 0;

    positional_array_list #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offer one request beat and return at the edge that accepts it.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                             input t_data val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.apply_request(act, pos, val);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_fill(input t_data v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_fill(v);
        i_cfg_we <= 1'b0;
    endtask

    // A small pool of values is favoured so that finds meet duplicates.
    function automatic t_data pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return t_data'(int'($urandom_range(4)) - 2);
        if (r < 36) return DATA_MIN;
        if (r < 42) return DATA_MAX;
        return t_data'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int unsigned highest);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return POS_W'($urandom_range(highest));
        if (r < 80) return POS_W'(sb.used);
        if (r < 88) return POS_W'(sb.used + 1);
        return POS_W'($urandom);
    endfunction

    // The list is steered towards a target length that changes every few dozen
    // beats, so that full, empty and everything in between are visited.
    task automatic send_random();
        int unsigned         r;
        int unsigned         n;
        int unsigned         grow_w;
        int unsigned         drop_w;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        t_data               val;
        if (seg_left == 0) begin
            seg_left = $urandom_range(80, 30);
            r = $urandom_range(99);
            target_len = (r < 30) ? LIST_DEPTH : (r < 45) ? 0 : $urandom_range(LIST_DEPTH);
        end
        seg_left--;
        n      = sb.used;
        grow_w = (n < target_len) ? 45 : (n == target_len) ? 22 : 12;
        drop_w = (n > target_len) ? 45 : (n == target_len) ? 22 : 12;
        r      = $urandom_range(grow_w + drop_w + 20 + 15 + 3 - 1);
        val    = pick_value();
        if (r < grow_w) begin
            act = $urandom_range(1) ? ACT_INSERT : ACT_APPEND;
            pos = (act == ACT_INSERT) ? pick_position(n) : POS_W'($urandom);
        end else if (r < grow_w + drop_w) begin
            act = ACT_DELETE;
            pos = pick_position(n > 0 ? n - 1 : 0);
        end else if (r < grow_w + drop_w + 20) begin
            act = ACT_FIND;
            pos = POS_W'($urandom);
            if (n > 0 && $urandom_range(99) < 60) val = sb.store[$urandom_range(n - 1)];
        end else if (r < grow_w + drop_w + 35) begin
            act = ACT_GET;
            pos = pick_position(n > 0 ? n - 1 : 0);
        end else begin
            act = ACTION_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
            pos = POS_W'($urandom);
        end
        send_item(act, pos, val);
    endtask

    task automatic run_directed();
        int a;
        send_item(ACT_GET,    8'd0,   '0);
        send_item(ACT_DELETE, 8'd0,   '0);
        send_item(ACT_FIND,   8'd0,   '0);
        send_item(ACT_INSERT, 8'd1,   t_data'(7));
        send_item(ACT_INSERT, 8'd0,   DATA_MAX);
        send_item(ACT_APPEND, 8'd255, DATA_MIN);
        send_item(ACT_APPEND, 8'd0,   '0);
        send_item(ACT_INSERT, 8'd3,   t_data'(-1));
        send_item(ACT_INSERT, 8'd1,   t_data'(5));
        send_item(ACT_APPEND, 8'd0,   t_data'(5));
        send_item(ACT_FIND,   8'd255, t_data'(5));
        send_item(ACT_FIND,   8'd0,   DATA_MIN);
        send_item(ACT_FIND,   8'd0,   t_data'(-1));
        // Differs from a stored entry in its lowest bit only.
        send_item(ACT_FIND,   8'd0,   DATA_MAX - 1);
        send_item(ACT_GET,    8'd0,   '0);
        send_item(ACT_GET,    8'd5,   '0);
        send_item(ACT_GET,    8'd6,   '0);
        send_item(ACT_GET,    8'd255, '0);
        send_item(ACT_DELETE, 8'd255, '0);
        send_item(ACT_DELETE, 8'd6,   '0);
        send_item(ACT_DELETE, 8'd0,   '0);
        send_item(ACT_DELETE, 8'd4,   '0);
        for (a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
            send_item(ACTION_W'(a), 8'hFF, t_data'($urandom));
        end
    endtask

    // Result side: checks every accepted beat and drives the stall, including
    // the long hold-off that backs the block up into its request port.
    initial begin : result_side
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_reply(o_status, o_found_index, o_read_value, o_count, o_is_empty);
            end
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : request_side
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 12;
        recv_idle_pct = 45;
        write_fill(DATA_MIN);
        run_directed();
        for (k = 0; k < 520; k++) send_random();
        settle();

        write_fill(DATA_MAX);
        send_idle_pct = 45;
        recv_idle_pct = 12;
        for (k = 0; k < 530; k++) begin
            if (k == 200) hold_asked++;
            send_random();
        end
        settle();

        write_fill(t_data'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < 270; k++) send_random();
        settle();

        write_fill('0);
        for (k = 0; k < 270; k++) send_random();
        settle();
        repeat (LIST_DEPTH + 8) @(posedge i_clk);

        $display("Run covered %0d requests and %0d result beats over %0d fill values.",
                 sb.requests, sb.replies, sb.fill_writes);
        $display("The list was full on %0d requests and empty on %0d failing requests.",
                 sb.full_hits, sb.empty_hits);
        if (sb.errors == 0 && sb.replies_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
